// ===== rtl/bmb_pkg.sv =====
// shared constants, types and divider interface for the bm25 block max bound unit
package bmb_pkg;

    localparam int BLOCK_SIZE = 128;
    localparam int FILL_W     = $clog2(BLOCK_SIZE + 1);

    localparam int TF_W     = 16;
    localparam int LEN_W    = 16;
    localparam int K1_W     = 16;
    localparam int B_W      = 15;
    localparam int AVG_W    = 24;
    localparam int SCORE_W  = 19;
    localparam int TALLY_W  = 32;
    localparam int SUM_W    = 48;
    localparam int RATIO_W  = 32;
    localparam int NUM_W    = 33;
    localparam int BPROD_W  = B_W + RATIO_W;
    localparam int T16_W    = 34;
    localparam int KPROD_W  = K1_W + T16_W;
    localparam int DEN_W    = 36;

    localparam int IN_DATA_W  = TF_W + LEN_W;
    localparam int OUT_FIELDS = 2 * SCORE_W + TALLY_W + SUM_W;
    localparam int OUT_DATA_W = ((OUT_FIELDS + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = AVG_W;

    localparam logic [K1_W-1:0]    K1_RESET  = K1_W'(19661);
    localparam logic [B_W-1:0]     B_RESET   = B_W'(12288);
    localparam logic [AVG_W-1:0]   AVG_RESET = '0;

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);
    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [K1_W:0]      ONE_Q14   = (K1_W + 1)'(16384);

    // iterative divider, two quotient bits per cycle
    localparam int DIV_REM_W  = DEN_W;
    localparam int DIV_BITS_W = 32;
    localparam int DIV_CNT_W  = 5;
    localparam logic [DIV_CNT_W-1:0] RATIO_PAIRS = DIV_CNT_W'(16);
    localparam logic [DIV_CNT_W-1:0] SCORE_PAIRS = DIV_CNT_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K1_GAIN        = 2'd0,
        CFG_LENGTH_WEIGHT  = 2'd1,
        CFG_AVERAGE_LENGTH = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                  start;
        logic [DIV_REM_W-1:0]  rem;
        logic [DIV_REM_W-1:0]  divisor;
        logic [DIV_BITS_W-1:0] bits;
        logic [DIV_CNT_W-1:0]  pairs;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIV_BITS_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/bmb_div.sv =====
// shared restoring divider, two quotient bits per cycle
module bmb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmb_pkg::t_div_req i_req,
    output bmb_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [bmb_pkg::DIV_REM_W-1:0]  r_rem;
    logic [bmb_pkg::DIV_REM_W-1:0]  r_div;
    logic [bmb_pkg::DIV_BITS_W-1:0] r_bits;
    logic [bmb_pkg::DIV_BITS_W-1:0] r_quot;
    logic [bmb_pkg::DIV_CNT_W-1:0]  r_cnt;

    logic [bmb_pkg::DIV_REM_W:0]    s1;
    logic [bmb_pkg::DIV_REM_W:0]    s2;
    logic [bmb_pkg::DIV_REM_W-1:0]  r1;
    logic [bmb_pkg::DIV_REM_W-1:0]  r2;
    logic                           ge1;
    logic                           ge2;

    always_comb begin
        s1  = {r_rem, r_bits[bmb_pkg::DIV_BITS_W-1]};
        ge1 = s1 >= {1'b0, r_div};
        r1  = ge1 ? bmb_pkg::DIV_REM_W'(s1 - {1'b0, r_div}) : s1[bmb_pkg::DIV_REM_W-1:0];
        s2  = {r1, r_bits[bmb_pkg::DIV_BITS_W-2]};
        ge2 = s2 >= {1'b0, r_div};
        r2  = ge2 ? bmb_pkg::DIV_REM_W'(s2 - {1'b0, r_div}) : s2[bmb_pkg::DIV_REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= i_req.rem;
                r_div  <= i_req.divisor;
                r_bits <= i_req.bits;
                r_cnt  <= i_req.pairs;
            end else if (r_busy) begin
                r_rem  <= r2;
                r_bits <= {r_bits[bmb_pkg::DIV_BITS_W-3:0], 2'b00};
                r_quot <= {r_quot[bmb_pkg::DIV_BITS_W-3:0], ge1, ge2};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == bmb_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== rtl/bm25_block_max_bound_unit.sv =====
// bm25 block max bound unit: per posting normalized score, block and list peaks, counters
// flow: a zero frequency goes straight to the update, a saturating score skips the score division,
// and a length ratio of one or a saturated ratio skips the length ratio division
// (the shared divider serves both the length ratio and the score, two quotient bits per cycle)
// one posting at a time; a stalled result holds the unit
// reset: synchronous active low, clears peaks, counters, output valid and loads register defaults
module bm25_block_max_bound_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [bmb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bmb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // term_freq, field_length
    input  logic [bmb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // list_last
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // block_bound, list_bound, postings_seen, freq_total, zero pad
    output logic [bmb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // list_done
    output logic                            m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATIO,
        S_MUL_T,
        S_NORM,
        S_MUL_K,
        S_DEN,
        S_SCORE,
        S_UPDATE
    } t_state;

    t_state r_state;

    logic [bmb_pkg::K1_W-1:0]    r_k1;
    logic [bmb_pkg::B_W-1:0]     r_b;
    logic [bmb_pkg::AVG_W-1:0]   r_avg;

    logic [bmb_pkg::TF_W-1:0]    r_tf;
    logic                        r_last;
    logic [bmb_pkg::RATIO_W-1:0] r_ratio;
    logic [bmb_pkg::BPROD_W-1:0] r_bprod;
    logic [bmb_pkg::NUM_W-1:0]   r_num;
    logic [bmb_pkg::T16_W-1:0]   r_t16;
    logic [bmb_pkg::KPROD_W-1:0] r_kprod;
    logic [bmb_pkg::SCORE_W-1:0] r_score;

    logic [bmb_pkg::SCORE_W-1:0] r_block_peak;
    logic [bmb_pkg::SCORE_W-1:0] r_list_peak;
    logic [bmb_pkg::FILL_W-1:0]  r_fill;
    logic [bmb_pkg::TALLY_W-1:0] r_tally;
    logic [bmb_pkg::SUM_W-1:0]   r_sum;

    logic                           r_out_valid;
    logic                           r_out_last;
    logic [bmb_pkg::OUT_DATA_W-1:0] r_out_data;

    bmb_pkg::t_div_req div_req;
    bmb_pkg::t_div_rsp div_rsp;

    logic [bmb_pkg::TF_W-1:0]    in_tf;
    logic [bmb_pkg::LEN_W-1:0]   in_len;
    logic                        in_fire;
    logic                        ratio_sat;
    logic                        ratio_div;
    logic [bmb_pkg::BPROD_W:0]   norm_pos;
    logic [bmb_pkg::BPROD_W:0]   norm_neg;
    logic [bmb_pkg::BPROD_W:0]   norm_diff;
    logic [bmb_pkg::DEN_W-1:0]   den;
    logic                        score_sat;
    logic [bmb_pkg::SCORE_W-1:0] n_block_peak;
    logic [bmb_pkg::SCORE_W-1:0] n_list_peak;
    logic [bmb_pkg::FILL_W-1:0]  n_fill;
    logic [bmb_pkg::TALLY_W-1:0] n_tally;
    logic [bmb_pkg::SUM_W:0]     sum_wide;
    logic [bmb_pkg::SUM_W-1:0]   n_sum;
    logic                        emit;
    logic                        out_load;

    assign in_tf         = s_axis_tdata[bmb_pkg::TF_W-1:0];
    assign in_len        = s_axis_tdata[bmb_pkg::IN_DATA_W-1:bmb_pkg::TF_W];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // quotient would not fit 32 bits
    assign ratio_sat = {16'd0, in_len} >= {r_avg, 8'd0};
    assign ratio_div = (in_len != '0) && (r_avg != '0) && !ratio_sat;

    always_comb begin
        norm_pos  = (bmb_pkg::BPROD_W + 1)'(r_bprod) + (bmb_pkg::BPROD_W + 1)'(64'd1 << 30);
        norm_neg  = (bmb_pkg::BPROD_W + 1)'({r_b, 16'd0});
        norm_diff = norm_pos - norm_neg;
    end

    assign den = bmb_pkg::DEN_W'({r_tf, 16'd0})
               + r_kprod[bmb_pkg::KPROD_W-1:bmb_pkg::KPROD_W-bmb_pkg::DEN_W];
    assign score_sat = {4'd0, r_num} >= {den, 1'b0};

    always_comb begin
        div_req = '0;
        if (r_state == S_IDLE && in_fire && in_tf != '0 && ratio_div) begin
            div_req.start   = 1'b1;
            div_req.rem     = bmb_pkg::DIV_REM_W'(in_len[15:8]);
            div_req.divisor = bmb_pkg::DIV_REM_W'(r_avg);
            div_req.bits    = {in_len[7:0], 24'd0};
            div_req.pairs   = bmb_pkg::RATIO_PAIRS;
        end else if (r_state == S_DEN && !score_sat) begin
            div_req.start   = 1'b1;
            div_req.rem     = bmb_pkg::DIV_REM_W'(r_num[bmb_pkg::NUM_W-1:2]);
            div_req.divisor = den;
            div_req.bits    = {r_num[1:0], 30'd0};
            div_req.pairs   = bmb_pkg::SCORE_PAIRS;
        end
    end

    bmb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_block_peak = (r_score > r_block_peak) ? r_score : r_block_peak;
        n_list_peak  = (r_score > r_list_peak) ? r_score : r_list_peak;
        n_fill       = r_fill + 1'b1;
        n_tally      = (r_tally == bmb_pkg::TALLY_MAX) ? r_tally : r_tally + 1'b1;
        sum_wide     = {1'b0, r_sum} + (bmb_pkg::SUM_W + 1)'(r_tf);
        n_sum        = sum_wide[bmb_pkg::SUM_W] ? bmb_pkg::SUM_MAX
                                                : sum_wide[bmb_pkg::SUM_W-1:0];
        emit         = (n_fill == bmb_pkg::FILL_W'(bmb_pkg::BLOCK_SIZE)) || r_last;
    end

    assign out_load = (r_state == S_UPDATE) && emit && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1  <= bmb_pkg::K1_RESET;
            r_b   <= bmb_pkg::B_RESET;
            r_avg <= bmb_pkg::AVG_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                bmb_pkg::CFG_K1_GAIN:        r_k1  <= i_cfg_data[bmb_pkg::K1_W-1:0];
                bmb_pkg::CFG_LENGTH_WEIGHT:  r_b   <= i_cfg_data[bmb_pkg::B_W-1:0];
                bmb_pkg::CFG_AVERAGE_LENGTH: r_avg <= i_cfg_data[bmb_pkg::AVG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_block_peak <= '0;
            r_list_peak  <= '0;
            r_fill       <= '0;
            r_tally      <= '0;
            r_sum        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_tf   <= in_tf;
                        r_last <= s_axis_tlast;
                        if (in_tf == '0) begin
                            r_score <= '0;
                            r_state <= S_UPDATE;
                        end else if (ratio_div) begin
                            r_state <= S_RATIO;
                        end else begin
                            r_ratio <= ratio_sat && in_len != '0 && r_avg != '0
                                     ? bmb_pkg::RATIO_MAX : bmb_pkg::RATIO_ONE;
                            r_state <= S_MUL_T;
                        end
                    end
                end
                S_RATIO: begin
                    if (div_rsp.done) begin
                        r_ratio <= div_rsp.quot;
                        r_state <= S_MUL_T;
                    end
                end
                S_MUL_T: begin
                    r_bprod <= r_b * r_ratio;
                    r_num   <= r_tf * (bmb_pkg::ONE_Q14 + (bmb_pkg::K1_W + 1)'(r_k1));
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    // weight above one can drive the norm negative
                    r_t16   <= (norm_pos > norm_neg) ? norm_diff[bmb_pkg::BPROD_W:14] : '0;
                    r_state <= S_MUL_K;
                end
                S_MUL_K: begin
                    r_kprod <= r_k1 * r_t16;
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    if (score_sat) begin
                        r_score <= bmb_pkg::SCORE_MAX;
                        r_state <= S_UPDATE;
                    end else begin
                        r_state <= S_SCORE;
                    end
                end
                S_SCORE: begin
                    if (div_rsp.done) begin
                        r_score <= div_rsp.quot[bmb_pkg::SCORE_W-1:0];
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (!emit) begin
                        r_block_peak <= n_block_peak;
                        r_list_peak  <= n_list_peak;
                        r_fill       <= n_fill;
                        r_tally      <= n_tally;
                        r_sum        <= n_sum;
                        r_state      <= S_IDLE;
                    end else if (!r_out_valid || m_axis_tready) begin
                        r_out_last   <= r_last;
                        r_out_data   <= bmb_pkg::OUT_DATA_W'({n_sum, n_tally,
                                                              n_list_peak, n_block_peak});
                        r_block_peak <= '0;
                        r_fill       <= '0;
                        r_list_peak  <= r_last ? '0 : n_list_peak;
                        r_tally      <= r_last ? '0 : n_tally;
                        r_sum        <= r_last ? '0 : n_sum;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/bmb_checker.sv =====
// port level checks for the bm25 block max bound unit and its bind
module bmb_props (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bmb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tlast
);

    localparam int LB_LO = bmb_pkg::SCORE_W;
    localparam int PS_LO = 2 * bmb_pkg::SCORE_W;

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one posting in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second posting taken while busy");

    a_block_le_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[bmb_pkg::SCORE_W-1:0]
                           <= m_axis_tdata[LB_LO+bmb_pkg::SCORE_W-1:LB_LO]))
        else $error("block bound above list bound");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[PS_LO+bmb_pkg::TALLY_W-1:PS_LO] != '0))
        else $error("result with zero postings");

endmodule

bind bm25_block_max_bound_unit bmb_props u_bmb_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
